>>> sv/fem_pkg.sv
// ----------------------------------------------------------------------------
// fem_pkg
// Shared types and codes for the feature exclusion mask block.
// ----------------------------------------------------------------------------
package fem_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned DIM_W   = 11;  // active width / height registers
  localparam int unsigned HALF_W  = 5;   // patch_half register
  localparam int unsigned COORD_W = 14;  // signed working width for mark bounds
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_NEW_FRAME = 2'd0,
    OP_MARK      = 2'd1,
    OP_READ      = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_W      = 2'd0,
    CFG_IMG_H      = 2'd1,
    CFG_PATCH_HALF = 2'd2
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MSETUP,
    ST_MFIRST,
    ST_MLOOP,
    ST_MEND,
    ST_RDMEM,
    ST_RESP
  } state_e;

  // Input item
  typedef struct packed {
    logic [1:0]         op;
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
    logic [9:0]         read_row;
    logic [3:0]         read_word;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [63:0] mask_word;
    logic [9:0]  word_row;
    logic [3:0]  word_index;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture accepted item
    logic clr_wr;    // write one all-ones row of the clearing sweep
    logic setup;     // latch mark bounds
    logic mark_rd;   // read next row of the mark
    logic mark_wr;   // write back previous row with patch cleared
    logic rd_issue;  // read row for a read item
    logic out_load;  // load result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;   // sweep at last row
    logic skip;       // mark point outside active image or in its first row or column
    logic last_issue; // row being read is the last of the patch
  } dp_sts_t;

endpackage

>>> sv/feature_exclusion_mask.sv
// ----------------------------------------------------------------------------
// feature_exclusion_mask
// One-bit-per-pixel exclusion mask with point marking and word read-out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_item_i): one item per accept.
//     new frame: sweeps every mask row to ones.
//     mark:      setup step, then one row per cycle, read and write back
//                overlapped; a skipped point ends after the setup step.
//     read:      memory read, then result load into the result register.
//   out channel (out_valid_o / out_stall_i / out_item_o): one item per read.
//     A pending result does not hold off new items; a read that arrives
//     while a result is still stalled waits until the register frees.
//   cfg channel (cfg_valid_i / cfg_ready_o): always ready; write only while
//     idle. Index 0 width, 1 height, 2 patch half size.
//   Rate is set by the single write port of the row-wide mask memory.
//   Reset: registers take their defaults and a clearing sweep runs
//     before the first item is accepted.
// ----------------------------------------------------------------------------
module feature_exclusion_mask #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fem_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fem_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fem_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fem_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  fem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_item_i.op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Memory and arithmetic
  fem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> sv/fem_ctrl.sv
// ----------------------------------------------------------------------------
// fem_ctrl
// Sequencer for clearing sweeps, patch marks and word reads.
// ----------------------------------------------------------------------------
module fem_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       in_op_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fem_pkg::dp_cmd_t cmd_o,
  input  fem_pkg::dp_sts_t sts_i
);
  import fem_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // State and result-valid registers; reset starts a clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.load = in_acc;
        if (in_acc) begin
          unique case (in_op_i)
            OP_NEW_FRAME: state_d = ST_CLEAR;
            OP_MARK:      state_d = ST_MSETUP;
            OP_READ:      state_d = ST_RDMEM;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_MSETUP: begin
        cmd_o.setup = 1'b1;
        state_d = sts_i.skip ? ST_IDLE : ST_MFIRST;
      end
      ST_MFIRST: begin
        cmd_o.mark_rd = 1'b1;
        state_d = sts_i.last_issue ? ST_MEND : ST_MLOOP;
      end
      ST_MLOOP: begin
        cmd_o.mark_rd = 1'b1;
        cmd_o.mark_wr = 1'b1;
        state_d = sts_i.last_issue ? ST_MEND : ST_MLOOP;
      end
      ST_MEND: begin
        cmd_o.mark_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RDMEM: begin
        cmd_o.rd_issue = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // wait for the result register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

endmodule

>>> sv/fem_datapath.sv
// ----------------------------------------------------------------------------
// fem_datapath
// Row-wide mask memory, configuration registers, patch bounds and read-out.
// ----------------------------------------------------------------------------
module fem_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fem_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fem_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  fem_pkg::in_item_t                   in_item_i,
  output fem_pkg::out_item_t                  out_item_o,
  input  fem_pkg::dp_cmd_t                    cmd_i,
  output fem_pkg::dp_sts_t                    sts_o
);
  import fem_pkg::*;

  localparam int unsigned ROW_WORDS = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ROW_BITS  = ROW_WORDS * WORD_BITS;
  localparam int unsigned RAW       = $clog2(MAX_HEIGHT);
  localparam int unsigned CLW       = $clog2(ROW_BITS);
  localparam int unsigned WIW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int unsigned CW        = COORD_W;

  localparam logic signed [CW-1:0] MAXW_S = CW'(MAX_WIDTH);
  localparam logic signed [CW-1:0] MAXH_S = CW'(MAX_HEIGHT);

  // Configuration registers
  logic [DIM_W-1:0]  width_q, height_q;
  logic [HALF_W-1:0] half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      half_q   <= HALF_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMG_W:      width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_IMG_H:      height_q <= cfg_data_i[DIM_W-1:0];
        CFG_PATCH_HALF: half_q   <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
  end

  // Patch bounds from the captured point
  logic signed [CW-1:0] px, py, pp, w_cfg, h_cfg, w_eff, h_eff, w_last, h_last;
  logic signed [CW-1:0] y_lo, y_hi, x_lo, x_hi, r0, r1, c0, c1;

  always_comb begin
    px     = {{(CW-12){item_q.point_x[11]}}, item_q.point_x};
    py     = {{(CW-12){item_q.point_y[11]}}, item_q.point_y};
    pp     = {{(CW-HALF_W){1'b0}}, half_q};
    w_cfg  = {{(CW-DIM_W){1'b0}}, width_q};
    h_cfg  = {{(CW-DIM_W){1'b0}}, height_q};
    w_eff  = (w_cfg > MAXW_S) ? MAXW_S : w_cfg;
    h_eff  = (h_cfg > MAXH_S) ? MAXH_S : h_cfg;
    w_last = w_eff - CW'(1);
    h_last = h_eff - CW'(1);
    y_lo   = py - pp;
    y_hi   = py + pp;
    x_lo   = px - pp;
    x_hi   = px + pp;
    r0     = (y_lo < 0) ? '0 : y_lo;
    r1     = (y_hi > h_last) ? h_last : y_hi;
    c0     = (x_lo < 0) ? '0 : x_lo;
    c1     = (x_hi > w_last) ? w_last : x_hi;
  end

  assign sts_o.skip = (px <= 0) || (px >= w_eff) || (py <= 0) || (py >= h_eff);

  // Mark row counters and column window
  logic [RAW-1:0] row_q, wr_row_q, r1_q;
  logic [CLW-1:0] c0_q, c1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      row_q <= r0[RAW-1:0];
      r1_q  <= r1[RAW-1:0];
      c0_q  <= c0[CLW-1:0];
      c1_q  <= c1[CLW-1:0];
    end else if (cmd_i.mark_rd) begin
      row_q    <= row_q + RAW'(1);
      wr_row_q <= row_q;
    end
  end

  assign sts_o.last_issue = (row_q == r1_q);

  // Column window as a bit mask over the row
  logic [ROW_BITS-1:0] col_hit;
  always_comb begin
    for (int i = 0; i < ROW_BITS; i++) begin
      col_hit[i] = (CLW'(i) >= c0_q) && (CLW'(i) <= c1_q);
    end
  end

  // Clearing sweep counter, restarted with each captured item
  logic [RAW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.load) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + RAW'(1);
    end
  end

  assign sts_o.clr_done = (clr_cnt_q == RAW'(MAX_HEIGHT - 1));

  // Read-item addressing
  logic [CW-1:0]  row_ext, word_ext;
  logic           row_ok, word_ok;
  logic [RAW-1:0] rd_row;
  logic [WIW-1:0] widx;

  assign row_ext  = {{(CW-10){1'b0}}, item_q.read_row};
  assign word_ext = {{(CW-4){1'b0}}, item_q.read_word};
  assign row_ok   = row_ext < CW'(MAX_HEIGHT);
  assign word_ok  = word_ext < CW'(ROW_WORDS);
  assign rd_row   = row_ext[RAW-1:0];
  assign widx     = word_ext[WIW-1:0];

  // Mask memory: one write port, one registered read port
  logic [ROW_BITS-1:0] mem [MAX_HEIGHT];
  logic [ROW_BITS-1:0] rd_data_q, wr_data;
  logic [RAW-1:0]      wr_addr, rd_addr;
  logic                we, re;

  assign we      = cmd_i.clr_wr || cmd_i.mark_wr;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : wr_row_q;
  assign wr_data = cmd_i.clr_wr ? '1 : (rd_data_q & ~col_hit);
  assign re      = cmd_i.mark_rd || cmd_i.rd_issue;
  assign rd_addr = cmd_i.rd_issue ? rd_row : row_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    if (re) rd_data_q <= mem[rd_addr];
  end

  // Result register
  logic [WORD_BITS-1:0] sel_word;
  out_item_t            out_q;

  assign sel_word = rd_data_q[widx*WORD_BITS +: WORD_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.mask_word  <= (row_ok && word_ok) ? 64'(sel_word) : 64'({WORD_BITS{1'b1}});
      out_q.word_row   <= item_q.read_row;
      out_q.word_index <= item_q.read_word;
    end
  end

  assign out_item_o = out_q;

endmodule

>>> sv/fem_checker.sv
// ----------------------------------------------------------------------------
// fem_checker
// Port-level assertions for the feature exclusion mask, bound to the top.
// ----------------------------------------------------------------------------
module fem_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fem_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fem_pkg::out_item_t out_item_o
);
  import fem_pkg::*;

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // Any real operation keeps the block busy for the following cycle
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.op == OP_NEW_FRAME ||
      in_item_i.op == OP_MARK || in_item_i.op == OP_READ) |=> in_stall_o)
    else $error("block accepted input right after an operation");

  // A result appears only out of the busy response step
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while block was idle");

endmodule

bind feature_exclusion_mask fem_checker u_fem_checker (.*);
